@@ src/hjc_pkg.sv @@
// ----------------------------------------------------------------------------
// hjc_pkg: shared types, constants and tables of the two-set Johab composer
// Jamo layout, pair tables, phase and result codes, queue and stack sizes.
// ----------------------------------------------------------------------------
package hjc_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] JOHAB_BASE = 16'h8441;
	localparam logic [15:0] MASK_INIT  = 16'h83FF;
	localparam logic [15:0] MASK_MED   = 16'hFC1F;
	localparam logic [15:0] MASK_FIN   = 16'hFFE0;

	localparam logic [7:0] VOWEL_MASK = 8'h60;
	localparam logic [7:0] VOWEL_TAG  = 8'h20;
	localparam logic [7:0] INIT_OFS   = 8'h80;
	localparam logic [7:0] MED_OFS    = 8'hA0;
	localparam logic [7:0] FIN_OFS    = 8'hC0;
	localparam logic [7:0] CONS_FIRST = 8'h82;
	localparam logic [7:0] CONS_COUNT = 8'd19;
	localparam logic [7:0] DBL_TT     = 8'h86;
	localparam logic [7:0] DBL_PP     = 8'h8A;
	localparam logic [7:0] DBL_JJ     = 8'h8F;

	localparam logic [7:0] KEY_BKSP = 8'd8;
	localparam logic [7:0] KEY_LO   = 8'd32;
	localparam logic [7:0] KEY_HI   = 8'd127;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_INIT  = 3'd1,
		PH_MED   = 3'd2,
		PH_DMED  = 3'd3,
		PH_FIN   = 3'd4,
		PH_DFIN  = 3'd5,
		PH_END1  = 3'd6,
		PH_END2  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SYL   = 2'd0,
		KIND_PLAIN = 2'd1,
		KIND_DEL   = 2'd2,
		KIND_PREV  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLS_PLAIN = 2'd0,
		CLS_BKSP  = 2'd1,
		CLS_JAMO  = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_HOLD = 2'd1,
		B_PEND = 2'd2,
		B_PREV = 2'd3
	} bstate_t;

	typedef struct packed {
		phase_t      ph;
		logic [15:0] code;
		logic [7:0]  key;
		logic [7:0]  raw;
	} entry_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] raw;
		logic [7:0] jamo;
	} key_item_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} fifo_stat_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] count;
	} back_stat_t;

	localparam logic [7:0] LAYOUT [96] = '{
		8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
		8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
		8'h40, 8'h88, 8'hBA, 8'h90, 8'h8D, 8'h86, 8'h87, 8'h94,
		8'hAD, 8'hA5, 8'hA7, 8'hA3, 8'hBD, 8'hBB, 8'hB4, 8'hA6,
		8'hAC, 8'h8A, 8'h83, 8'h84, 8'h8C, 8'hAB, 8'h93, 8'h8F,
		8'h92, 8'hB3, 8'h91, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
		8'h60, 8'h88, 8'hBA, 8'h90, 8'h8D, 8'h85, 8'h87, 8'h94,
		8'hAD, 8'hA5, 8'hA7, 8'hA3, 8'hBD, 8'hBB, 8'hB4, 8'hA4,
		8'hAA, 8'h89, 8'h82, 8'h84, 8'h8B, 8'hAB, 8'h93, 8'h8E,
		8'h92, 8'hB3, 8'h91, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F
	};

	function automatic key_item_t classify(input logic [7:0] key, input logic mode);
		key_item_t  it;
		logic [7:0] conv;
		conv = key;
		if (!mode && key > KEY_LO && key <= KEY_HI) begin
			conv = LAYOUT[7'(key - KEY_LO)];
		end
		it.raw  = key;
		it.jamo = conv;
		if (conv != key) begin
			it.cls = CLS_JAMO;
		end else if (key == KEY_BKSP) begin
			it.cls = CLS_BKSP;
		end else begin
			it.cls = CLS_PLAIN;
		end
		return it;
	endfunction

	function automatic logic [7:0] vowel_pair(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		case ({a, b})
			16'hADA3: r = 8'hAE;
			16'hADA4: r = 8'hAF;
			16'hADBD: r = 8'hB2;
			16'hB4A7: r = 8'hB5;
			16'hB4AA: r = 8'hB6;
			16'hB4BD: r = 8'hB7;
			16'hBBBD: r = 8'hBC;
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] final_pair(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		case ({a, b})
			16'h828B: r = 8'hC4;
			16'h848E: r = 8'hC6;
			16'h8494: r = 8'hC7;
			16'h8782: r = 8'hCA;
			16'h8788: r = 8'hCB;
			16'h8789: r = 8'hCC;
			16'h878B: r = 8'hCD;
			16'h8792: r = 8'hCE;
			16'h8793: r = 8'hCF;
			16'h8794: r = 8'hD0;
			16'h898B: r = 8'hD4;
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

	// final-consonant code for initial code CONS_FIRST + p
	function automatic logic [7:0] init_to_final(input logic [4:0] p);
		logic [7:0] r;
		case (p)
			5'd0:    r = 8'hC2;
			5'd1:    r = 8'hC3;
			5'd2:    r = 8'hC5;
			5'd3:    r = 8'hC8;
			5'd5:    r = 8'hC9;
			5'd6:    r = 8'hD1;
			5'd7:    r = 8'hD3;
			5'd9:    r = 8'hD5;
			5'd10:   r = 8'hD6;
			5'd11:   r = 8'hD7;
			5'd12:   r = 8'hD8;
			5'd14:   r = 8'hD9;
			5'd15:   r = 8'hDA;
			5'd16:   r = 8'hDB;
			5'd17:   r = 8'hDC;
			5'd18:   r = 8'hDD;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ src/hjc_if.sv @@
// ----------------------------------------------------------------------------
// hjc_if: channel interfaces of the Johab composer
// Key input, result output and mode write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface hjc_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

interface hjc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] code;
	logic        last;
	modport source (output valid, output kind, output code, output last, input ready);
	modport sink (input valid, input kind, input code, input last, output ready);
endinterface

interface hjc_cfg_if;
	logic valid;
	logic ready;
	logic input_mode;
	modport source (output valid, output input_mode, input ready);
	modport sink (input valid, input input_mode, output ready);
endinterface

@@ src/hjc_fifo.sv @@
// ----------------------------------------------------------------------------
// hjc_fifo: queue of classified keys between front and back
// Small circular buffer; head is presented combinationally.
// ----------------------------------------------------------------------------
module hjc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hjc_pkg::key_item_t    wr_item,
	input  logic                  pop,
	output hjc_pkg::key_item_t    head,
	output hjc_pkg::fifo_stat_t   stat
);

	hjc_pkg::key_item_t                mem_q [hjc_pkg::QUEUE_DEPTH];
	logic [hjc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [hjc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [hjc_pkg::QCNT_W-1:0]        cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hjc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hjc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + hjc_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - hjc_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == hjc_pkg::QCNT_W'(hjc_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

@@ src/hjc_front.sv @@
// ----------------------------------------------------------------------------
// hjc_front: key intake, layout mapping and mode register
// Registers each accepted key with its class and jamo code, then queues it.
// ----------------------------------------------------------------------------
module hjc_front (
	input  logic                clk,
	input  logic                arst_n,
	hjc_key_if.sink             key,
	hjc_cfg_if.sink             cfg,
	input  hjc_pkg::fifo_stat_t q_stat,
	output logic                q_push,
	output hjc_pkg::key_item_t  q_item,
	output logic                mode
);

	logic               mode_q;
	logic               vld_s1;
	hjc_pkg::key_item_t item_s1;
	logic               take;

	assign q_push    = vld_s1 && !q_stat.full;
	assign q_item    = item_s1;
	assign key.ready = !vld_s1 || q_push;
	assign take      = key.valid && key.ready;
	assign cfg.ready = 1'b1;
	assign mode      = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.input_mode;
			end
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (q_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= hjc_pkg::classify(key.key_code, mode_q);
		end
	end

endmodule

@@ src/hjc_back.sv @@
// ----------------------------------------------------------------------------
// hjc_back: composition automaton and result sequencer
// Steps one key at a time and takes the next queued key only after its preview;
// one result per cycle into the output register while it is free; re-fed keys
// are stepped from a two-entry pending store.
module hjc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mode,
	input  hjc_pkg::key_item_t  q_head,
	input  hjc_pkg::fifo_stat_t q_stat,
	output logic                q_pop,
	output hjc_pkg::back_stat_t stat,
	hjc_res_if.source           res
);

	hjc_pkg::bstate_t             state_q, state_d;
	hjc_pkg::phase_t              phase_q;
	logic [hjc_pkg::CNT_W-1:0]    count_q;
	hjc_pkg::entry_t              top_q;
	hjc_pkg::entry_t              stk_q [hjc_pkg::STACK_DEPTH];
	logic [7:0]                   pend_q [2];
	logic [1:0]                   pcnt_q;
	logic [7:0]                   hold_key_q;

	logic                         res_v_q;
	hjc_pkg::kind_t               res_kind_q;
	logic [15:0]                  res_code_q;
	logic                         res_last_q;

	logic                         out_free;
	logic                         from_pend;
	logic                         step_en;
	hjc_pkg::key_item_t           item;
	hjc_pkg::entry_t              below;
	logic [hjc_pkg::IDX_W-1:0]    below_idx;
	logic [hjc_pkg::IDX_W-1:0]    push_idx;
	logic                         at_start;

	logic                         vowel;
	logic                         can_fin;
	logic [7:0]                   vp;
	logic [7:0]                   fp;
	logic [7:0]                   jcode;
	logic [7:0]                   fpos;
	logic [7:0]                   fcode;
	logic [15:0]                  tu;
	hjc_pkg::phase_t              nx;

	logic                         s_r0_v;
	hjc_pkg::kind_t               s_r0_kind;
	logic [15:0]                  s_r0_code;
	logic                         s_r1_v;
	hjc_pkg::phase_t              s_phase;
	logic [hjc_pkg::CNT_W-1:0]    s_count;
	hjc_pkg::entry_t              s_top;
	logic                         s_push;
	logic                         s_pend_raw;
	logic                         s_pend_uok;

	logic [1:0]                   pc;
	logic [7:0]                   pend_d [2];

	logic                         emit_v;
	hjc_pkg::kind_t               emit_kind;
	logic [15:0]                  emit_code;
	logic                         emit_last;

	assign out_free  = !res_v_q || res.ready;
	assign from_pend = (state_q == hjc_pkg::B_PEND);
	assign item      = from_pend ? hjc_pkg::classify(pend_q[1'(pcnt_q - 2'd1)], mode) : q_head;
	assign below_idx = hjc_pkg::IDX_W'(count_q - hjc_pkg::CNT_W'(2));
	assign below     = stk_q[below_idx];
	assign push_idx  = (count_q < hjc_pkg::CNT_W'(hjc_pkg::STACK_DEPTH)) ?
		count_q[hjc_pkg::IDX_W-1:0] : hjc_pkg::IDX_W'(hjc_pkg::STACK_DEPTH - 1);
	assign at_start  = (phase_q == hjc_pkg::PH_START);

	// jamo classification and next phase
	always_comb begin
		vowel   = (item.jamo & hjc_pkg::VOWEL_MASK) == hjc_pkg::VOWEL_TAG;
		can_fin = !vowel && item.jamo != hjc_pkg::DBL_TT && item.jamo != hjc_pkg::DBL_PP &&
			item.jamo != hjc_pkg::DBL_JJ;
		vp      = hjc_pkg::vowel_pair(top_q.key, item.jamo);
		fp      = hjc_pkg::final_pair(top_q.key, item.jamo);
		jcode   = item.jamo;
		unique case (phase_q)
			hjc_pkg::PH_INIT: begin
				nx = vowel ? hjc_pkg::PH_MED : hjc_pkg::PH_END1;
			end
			hjc_pkg::PH_MED: begin
				if (can_fin) begin
					nx = hjc_pkg::PH_FIN;
				end else if (vp != 8'h00) begin
					nx    = hjc_pkg::PH_DMED;
					jcode = vp;
				end else begin
					nx = hjc_pkg::PH_END1;
				end
			end
			hjc_pkg::PH_DMED: begin
				nx = can_fin ? hjc_pkg::PH_FIN : hjc_pkg::PH_END1;
			end
			hjc_pkg::PH_FIN: begin
				if (!vowel && fp != 8'h00) begin
					nx    = hjc_pkg::PH_DFIN;
					jcode = fp;
				end else begin
					nx = vowel ? hjc_pkg::PH_END2 : hjc_pkg::PH_END1;
				end
			end
			hjc_pkg::PH_DFIN: begin
				nx = vowel ? hjc_pkg::PH_END2 : hjc_pkg::PH_END1;
			end
			default: begin
				nx = vowel ? hjc_pkg::PH_MED : hjc_pkg::PH_INIT;
			end
		endcase
		fpos  = 8'(jcode - hjc_pkg::CONS_FIRST);
		fcode = (fpos < hjc_pkg::CONS_COUNT) ? hjc_pkg::init_to_final(fpos[4:0]) :
			hjc_pkg::FIN_OFS;
		tu    = at_start ? hjc_pkg::JOHAB_BASE : top_q.code;
	end

	// one key step
	always_comb begin
		s_r0_v     = 1'b0;
		s_r0_kind  = hjc_pkg::KIND_SYL;
		s_r0_code  = '0;
		s_r1_v     = 1'b0;
		s_phase    = phase_q;
		s_count    = count_q;
		s_top      = top_q;
		s_push     = 1'b0;
		s_pend_raw = 1'b0;
		s_pend_uok = 1'b0;
		unique case (item.cls)
			hjc_pkg::CLS_BKSP: begin
				if (at_start || count_q == '0) begin
					s_r0_v    = 1'b1;
					s_r0_kind = hjc_pkg::KIND_DEL;
					s_phase   = hjc_pkg::PH_START;
					s_count   = '0;
				end else begin
					s_count = count_q - hjc_pkg::CNT_W'(1);
					if (count_q == hjc_pkg::CNT_W'(1)) begin
						s_phase = hjc_pkg::PH_START;
					end else begin
						s_phase = below.ph;
						s_top   = below;
					end
				end
			end
			hjc_pkg::CLS_PLAIN: begin
				s_r0_v = 1'b1;
				if (!at_start) begin
					s_r0_kind = hjc_pkg::KIND_SYL;
					s_r0_code = top_q.code;
					s_r1_v    = 1'b1;
				end else begin
					s_r0_kind = hjc_pkg::KIND_PLAIN;
					s_r0_code = {8'h00, item.raw};
				end
				s_phase = hjc_pkg::PH_START;
				s_count = '0;
			end
			default: begin
				s_top.ph  = nx;
				s_top.key = item.jamo;
				s_top.raw = item.raw;
				s_top.code = tu;
				unique case (nx)
					hjc_pkg::PH_INIT: begin
						s_top.code = (tu & hjc_pkg::MASK_INIT) |
							(16'(5'(jcode - hjc_pkg::INIT_OFS)) << 10);
					end
					hjc_pkg::PH_MED, hjc_pkg::PH_DMED: begin
						s_top.code = (tu & hjc_pkg::MASK_MED) |
							(16'(5'(jcode - hjc_pkg::MED_OFS)) << 5);
					end
					hjc_pkg::PH_FIN: begin
						s_top.code = (tu & hjc_pkg::MASK_FIN) |
							16'(5'(fcode - hjc_pkg::FIN_OFS));
					end
					hjc_pkg::PH_DFIN: begin
						s_top.code = (tu & hjc_pkg::MASK_FIN) |
							16'(5'(jcode - hjc_pkg::FIN_OFS));
					end
					default: begin
						s_top.code = tu;
					end
				endcase
				if (nx == hjc_pkg::PH_END1) begin
					s_r0_v     = 1'b1;
					s_r0_code  = top_q.code;
					s_phase    = hjc_pkg::PH_START;
					s_count    = '0;
					s_top      = top_q;
					s_pend_raw = 1'b1;
				end else if (nx == hjc_pkg::PH_END2) begin
					s_r0_v     = 1'b1;
					s_r0_code  = below.code;
					s_phase    = hjc_pkg::PH_START;
					s_count    = '0;
					s_top      = top_q;
					s_pend_raw = 1'b1;
					s_pend_uok = 1'b1;
				end else if (at_start && (nx == hjc_pkg::PH_MED || nx == hjc_pkg::PH_DMED)) begin
					// lone vowel: finished at once with filler initial
					s_r0_v    = 1'b1;
					s_r0_code = s_top.code;
					s_phase   = hjc_pkg::PH_START;
					s_count   = '0;
				end else begin
					s_push  = 1'b1;
					s_phase = nx;
					s_count = hjc_pkg::CNT_W'(push_idx) + hjc_pkg::CNT_W'(1);
				end
			end
		endcase
	end

	// pending store after the step
	always_comb begin
		pend_d[0] = pend_q[0];
		pend_d[1] = pend_q[1];
		pc        = from_pend ? pcnt_q - 2'd1 : 2'd0;
		if (s_pend_raw && pc < 2'd2) begin
			pend_d[pc[0]] = item.raw;
			pc            = pc + 2'd1;
		end
		if (s_pend_uok && pc < 2'd2) begin
			pend_d[pc[0]] = top_q.raw;
			pc            = pc + 2'd1;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		step_en   = 1'b0;
		q_pop     = 1'b0;
		emit_v    = 1'b0;
		emit_kind = s_r0_kind;
		emit_code = s_r0_code;
		emit_last = 1'b0;
		unique case (state_q)
			hjc_pkg::B_IDLE, hjc_pkg::B_PEND: begin
				if (out_free && (from_pend || !q_stat.empty)) begin
					step_en = 1'b1;
					q_pop   = !from_pend;
					emit_v  = s_r0_v;
					if (s_r1_v) begin
						state_d = hjc_pkg::B_HOLD;
					end else if (pc != 2'd0) begin
						state_d = hjc_pkg::B_PEND;
					end else begin
						state_d = hjc_pkg::B_PREV;
					end
				end
			end
			hjc_pkg::B_HOLD: begin
				if (out_free) begin
					emit_v    = 1'b1;
					emit_kind = hjc_pkg::KIND_PLAIN;
					emit_code = {8'h00, hold_key_q};
					state_d   = (pcnt_q != 2'd0) ? hjc_pkg::B_PEND : hjc_pkg::B_PREV;
				end
			end
			default: begin
				if (out_free) begin
					emit_v    = 1'b1;
					emit_kind = hjc_pkg::KIND_PREV;
					emit_code = at_start ? 16'h0000 : top_q.code;
					emit_last = 1'b1;
					state_d   = hjc_pkg::B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hjc_pkg::B_IDLE;
			phase_q <= hjc_pkg::PH_START;
			count_q <= '0;
			pcnt_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step_en) begin
				phase_q <= s_phase;
				count_q <= s_count;
				pcnt_q  <= pc;
			end
			if (emit_v) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			top_q     <= s_top;
			pend_q[0] <= pend_d[0];
			pend_q[1] <= pend_d[1];
			if (s_push) begin
				stk_q[push_idx] <= s_top;
			end
			if (s_r1_v) begin
				hold_key_q <= item.raw;
			end
		end
		if (emit_v) begin
			res_kind_q <= emit_kind;
			res_code_q <= emit_code;
			res_last_q <= emit_last;
		end
	end

	assign res.valid  = res_v_q;
	assign res.kind   = res_kind_q;
	assign res.code   = res_code_q;
	assign res.last   = res_last_q;
	assign stat.phase = phase_q;
	assign stat.count = count_q;

endmodule

@@ src/hangul_two_set_johab_composer_top.sv @@
// ----------------------------------------------------------------------------
// hangul_two_set_johab_composer_top: two-set Hangul composer, Johab output
//
//   channel  dir  transaction
//   key      in   one key byte (key_code)
//   res      out  one result: kind, code, last
//   cfg      in   input_mode write
//
// In the back end a key is stepped, then previewed; re-fed keys are stepped in between
// from the pending store, a plain key ending a syllable is sent after it, and a final
// consonant moving on is re-fed with the vowel. One result per cycle enters the single
// output register; the sequencer waits while it is held. Reset leaves the entry stack
// undefined. Keys are taken while results stall: a front stage and a four-entry queue.
// ----------------------------------------------------------------------------
module hangul_two_set_johab_composer_top (
	input  logic      clk,
	input  logic      arst_n,
	hjc_key_if.sink   key,
	hjc_res_if.source res,
	hjc_cfg_if.sink   cfg
);

	logic                q_push;
	logic                q_pop;
	logic                mode;
	hjc_pkg::key_item_t  q_item;
	hjc_pkg::key_item_t  q_head;
	hjc_pkg::fifo_stat_t q_stat;
	hjc_pkg::back_stat_t stat;

	hjc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.cfg    (cfg),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_item (q_item),
		.mode   (mode)
	);

	hjc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_item),
		.pop     (q_pop),
		.head    (q_head),
		.stat    (q_stat)
	);

	hjc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode),
		.q_head (q_head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.stat   (stat),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_phase_count: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.phase == hjc_pkg::PH_START) == (stat.count == '0))
		else $error("phase and stack count disagree");

	a_stack_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count < hjc_pkg::CNT_W'(hjc_pkg::STACK_DEPTH))
		else $error("entry stack full");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");
`endif

endmodule

@@ verif/hangul_two_set_johab_composer_top_tb.sv @@
// ----------------------------------------------------------------------------
// hangul_two_set_johab_composer_top_tb: self-checking bench of the Johab composer
// Drives key and mode transactions, predicts every result from its own model
// of the two-set automaton and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module hangul_two_set_johab_composer_top_tb;

	localparam int RUN_LIMIT = 200000;

	typedef struct packed {
		hjc_pkg::kind_t kind;
		logic [15:0]    code;
		logic           last;
	} johab_out_t;

	localparam logic [7:0] UPPER_JAMO [26] = '{
		8'h88, 8'hBA, 8'h90, 8'h8D, 8'h86, 8'h87, 8'h94, 8'hAD, 8'hA5, 8'hA7,
		8'hA3, 8'hBD, 8'hBB, 8'hB4, 8'hA6, 8'hAC, 8'h8A, 8'h83, 8'h84, 8'h8C,
		8'hAB, 8'h93, 8'h8F, 8'h92, 8'hB3, 8'h91
	};
	localparam logic [7:0] LOWER_JAMO [26] = '{
		8'h88, 8'hBA, 8'h90, 8'h8D, 8'h85, 8'h87, 8'h94, 8'hAD, 8'hA5, 8'hA7,
		8'hA3, 8'hBD, 8'hBB, 8'hB4, 8'hA4, 8'hAA, 8'h89, 8'h82, 8'h84, 8'h8B,
		8'hAB, 8'h93, 8'h8E, 8'h92, 8'hB3, 8'h91
	};
	localparam logic [23:0] VOWEL_MERGE [7] = '{
		24'hADA3AE, 24'hADA4AF, 24'hADBDB2, 24'hB4A7B5, 24'hB4AAB6, 24'hB4BDB7,
		24'hBBBDBC
	};
	localparam logic [23:0] FINAL_MERGE [11] = '{
		24'h828BC4, 24'h848EC6, 24'h8494C7, 24'h8782CA, 24'h8788CB, 24'h8789CC,
		24'h878BCD, 24'h8792CE, 24'h8793CF, 24'h8794D0, 24'h898BD4
	};
	localparam logic [7:0] FINAL_OF_INIT [19] = '{
		8'hC2, 8'hC3, 8'hC5, 8'hC8, 8'h00, 8'hC9, 8'hD1, 8'hD3, 8'h00, 8'hD5,
		8'hD6, 8'hD7, 8'hD8, 8'h00, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD
	};
	localparam int SRC_IDLE [4] = '{0, 47, 0, 36};
	localparam int SNK_IDLE [4] = '{0, 0, 47, 36};

	logic clk;
	logic arst_n;

	hjc_key_if key_ch ();
	hjc_res_if res_ch ();
	hjc_cfg_if cfg_ch ();

	hangul_two_set_johab_composer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// composer state as predicted
	logic             mode_q;
	hjc_pkg::phase_t  comp_phase;
	hjc_pkg::entry_t  comp_stack [hjc_pkg::STACK_DEPTH];
	int               comp_depth;
	logic [7:0]       refeed [2];
	int               refeed_n;
	johab_out_t       key_outs [$];
	johab_out_t       outputs_due [$];

	logic [7:0] cons_keys [$];
	logic [7:0] vowel_keys [$];
	logic [7:0] plain_keys [$];

	int src_idle_pct;
	int snk_stall_pct;
	int hold_req;
	int hold_left;
	int keys_sent;
	int fail_cnt;
	int cycle_cnt;

	function automatic logic [7:0] jamo_of(input logic [7:0] k);
		if (k >= 8'h41 && k <= 8'h5A) begin
			return UPPER_JAMO[k - 8'h41];
		end else if (k >= 8'h61 && k <= 8'h7A) begin
			return LOWER_JAMO[k - 8'h61];
		end
		return k;
	endfunction

	function automatic logic [7:0] key_for(input logic [7:0] jamo);
		logic [7:0] k;
		for (int i = 0; i < 52; i++) begin
			k = (i < 26) ? 8'(8'h61 + i) : 8'(8'h41 + i - 26);
			if (jamo_of(k) == jamo) begin
				return k;
			end
		end
		return 8'h00;
	endfunction

	function automatic logic [7:0] merge_lookup(input logic is_vowel, input logic [7:0] a,
			input logic [7:0] b);
		logic [23:0] e;
		for (int i = 0; i < (is_vowel ? 7 : 11); i++) begin
			e = is_vowel ? VOWEL_MERGE[i] : FINAL_MERGE[i];
			if (e[23:16] == a && e[15:8] == b) begin
				return e[7:0];
			end
		end
		return 8'h00;
	endfunction

	function automatic logic [15:0] top_syllable();
		return (comp_depth > 0) ? comp_stack[comp_depth - 1].code : 16'h0000;
	endfunction

	function automatic void note_out(input hjc_pkg::kind_t kind, input logic [15:0] code);
		johab_out_t o;
		o.kind = kind;
		o.code = code;
		o.last = 1'b0;
		if (key_outs.size() < 4) begin
			key_outs.push_back(o);
		end
	endfunction

	function automatic void push_comp(input hjc_pkg::phase_t ph, input logic [15:0] code,
			input logic [7:0] jamo, input logic [7:0] raw);
		int idx;
		idx = (comp_depth < hjc_pkg::STACK_DEPTH) ? comp_depth : hjc_pkg::STACK_DEPTH - 1;
		comp_stack[idx].ph   = ph;
		comp_stack[idx].code = code;
		comp_stack[idx].key  = jamo;
		comp_stack[idx].raw  = raw;
		comp_depth = idx + 1;
	endfunction

	function automatic void add_refeed(input logic [7:0] raw);
		if (refeed_n < 2) begin
			refeed[refeed_n] = raw;
			refeed_n++;
		end
	endfunction

	// one jamo into the automaton; 1 when a syllable is finished (left on top)
	function automatic logic compose_jamo(input logic [7:0] k, input logic [7:0] raw);
		logic            vowel;
		logic            can_fin;
		logic [15:0]     tu;
		logic [7:0]      prev_jamo;
		logic [7:0]      prev_raw;
		logic [7:0]      c;
		logic [7:0]      m;
		logic [7:0]      d;
		hjc_pkg::phase_t nx;
		hjc_pkg::phase_t old;
		vowel     = (k & 8'h60) == 8'h20;
		can_fin   = !vowel && k != 8'h86 && k != 8'h8A && k != 8'h8F;
		tu        = 16'h8441;
		prev_jamo = 8'h00;
		prev_raw  = 8'h00;
		c         = k;
		old       = comp_phase;
		if (comp_phase != hjc_pkg::PH_START && comp_depth > 0) begin
			tu        = comp_stack[comp_depth - 1].code;
			prev_jamo = comp_stack[comp_depth - 1].key;
			prev_raw  = comp_stack[comp_depth - 1].raw;
		end
		case (comp_phase)
			hjc_pkg::PH_INIT: nx = vowel ? hjc_pkg::PH_MED : hjc_pkg::PH_END1;
			hjc_pkg::PH_MED: begin
				m = merge_lookup(1'b1, prev_jamo, k);
				if (can_fin) begin
					nx = hjc_pkg::PH_FIN;
				end else if (m != 8'h00) begin
					c  = m;
					nx = hjc_pkg::PH_DMED;
				end else begin
					nx = hjc_pkg::PH_END1;
				end
			end
			hjc_pkg::PH_DMED: nx = can_fin ? hjc_pkg::PH_FIN : hjc_pkg::PH_END1;
			hjc_pkg::PH_FIN: begin
				m = vowel ? 8'h00 : merge_lookup(1'b0, prev_jamo, k);
				if (m != 8'h00) begin
					c  = m;
					nx = hjc_pkg::PH_DFIN;
				end else begin
					nx = vowel ? hjc_pkg::PH_END2 : hjc_pkg::PH_END1;
				end
			end
			hjc_pkg::PH_DFIN: nx = vowel ? hjc_pkg::PH_END2 : hjc_pkg::PH_END1;
			default: begin
				old = hjc_pkg::PH_START;
				nx  = vowel ? hjc_pkg::PH_MED : hjc_pkg::PH_INIT;
			end
		endcase
		case (nx)
			hjc_pkg::PH_INIT: begin
				d  = c - 8'h80;
				tu = {tu[15], d[4:0], tu[9:0]};
			end
			hjc_pkg::PH_MED, hjc_pkg::PH_DMED: begin
				d  = c - 8'hA0;
				tu = {tu[15:10], d[4:0], tu[4:0]};
				if (old == hjc_pkg::PH_START) begin
					// lone vowel: finished at once with the filler initial
					push_comp(nx, tu, k, raw);
					comp_phase = hjc_pkg::PH_START;
					return 1'b1;
				end
			end
			hjc_pkg::PH_FIN, hjc_pkg::PH_DFIN: begin
				if (nx == hjc_pkg::PH_FIN) begin
					d = c - 8'h82;
					c = (d < 8'd19) ? FINAL_OF_INIT[d] : 8'hC0;
				end
				d  = c - 8'hC0;
				tu = {tu[15:5], d[4:0]};
			end
			hjc_pkg::PH_END1: begin
				comp_phase = hjc_pkg::PH_START;
				add_refeed(raw);
				return 1'b1;
			end
			default: begin
				// final consonant moves on to the next syllable
				comp_phase = hjc_pkg::PH_START;
				add_refeed(raw);
				add_refeed(prev_raw);
				if (comp_depth > 0) begin
					comp_depth--;
				end
				return 1'b1;
			end
		endcase
		push_comp(nx, tu, k, raw);
		comp_phase = nx;
		return 1'b0;
	endfunction

	function automatic void handle_key(input logic [7:0] key);
		logic [7:0] conv;
		conv = key;
		if (!mode_q && key > 8'd32 && key <= 8'd127) begin
			conv = jamo_of(key);
		end
		if (conv == key) begin
			if (key == hjc_pkg::KEY_BKSP) begin
				if (comp_phase == hjc_pkg::PH_START || comp_depth == 0) begin
					comp_phase = hjc_pkg::PH_START;
					comp_depth = 0;
					note_out(hjc_pkg::KIND_DEL, 16'h0000);
				end else begin
					comp_depth--;
					comp_phase = (comp_depth > 0) ? comp_stack[comp_depth - 1].ph :
						hjc_pkg::PH_START;
				end
			end else begin
				if (comp_phase != hjc_pkg::PH_START) begin
					note_out(hjc_pkg::KIND_SYL, top_syllable());
				end
				note_out(hjc_pkg::KIND_PLAIN, {8'h00, key});
				comp_phase = hjc_pkg::PH_START;
				comp_depth = 0;
			end
		end else if (compose_jamo(conv, key)) begin
			note_out(hjc_pkg::KIND_SYL, top_syllable());
			comp_phase = hjc_pkg::PH_START;
			comp_depth = 0;
		end
	endfunction

	function automatic void compose_key(input logic [7:0] key);
		key_outs.delete();
		refeed_n = 0;
		handle_key(key);
		while (refeed_n > 0) begin
			refeed_n--;
			handle_key(refeed[refeed_n]);
		end
		note_out(hjc_pkg::KIND_PREV,
			(comp_phase != hjc_pkg::PH_START) ? top_syllable() : 16'h0000);
		key_outs[key_outs.size() - 1].last = 1'b1;
		foreach (key_outs[i]) begin
			outputs_due.push_back(key_outs[i]);
		end
	endfunction

	function automatic void fill_key_sets();
		logic [7:0] j;
		for (int k = 32; k < 128; k++) begin
			j = jamo_of(8'(k));
			if (j == 8'(k)) begin
				plain_keys.push_back(8'(k));
			end else if ((j & 8'h60) == 8'h20) begin
				vowel_keys.push_back(8'(k));
			end else begin
				cons_keys.push_back(8'(k));
			end
		end
	endfunction

	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			return cons_keys[$urandom_range(cons_keys.size() - 1)];
		end else if (r < 74) begin
			return vowel_keys[$urandom_range(vowel_keys.size() - 1)];
		end else if (r < 82) begin
			return hjc_pkg::KEY_BKSP;
		end else if (r < 90) begin
			return plain_keys[$urandom_range(plain_keys.size() - 1)];
		end
		return 8'($urandom_range(255));
	endfunction

	// entered and left just after a falling edge
	task automatic send_key(input logic [7:0] k);
		while ($urandom_range(99) < src_idle_pct) begin
			key_ch.valid = 1'b0;
			@(negedge clk);
		end
		key_ch.valid    = 1'b1;
		key_ch.key_code = k;
		do @(posedge clk); while (!key_ch.ready);
		compose_key(k);
		keys_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_key(s[i]);
		end
	endtask

	task automatic wait_all_out();
		key_ch.valid = 1'b0;
		while (outputs_due.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_all_out();
		repeat (4) @(negedge clk);
		cfg_ch.valid      = 1'b1;
		cfg_ch.input_mode = m;
		do @(posedge clk); while (!cfg_ch.ready);
		mode_q = m;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// initial consonant, vowel or vowel pair, optional final, final pair or backspaced final, optional vowel
	task automatic send_syllable();
		logic [23:0] e;
		send_key(cons_keys[$urandom_range(cons_keys.size() - 1)]);
		if ($urandom_range(3) == 0) begin
			e = VOWEL_MERGE[$urandom_range(6)];
			send_key(key_for(e[23:16]));
			send_key(key_for(e[15:8]));
		end else begin
			send_key(vowel_keys[$urandom_range(vowel_keys.size() - 1)]);
		end
		case ($urandom_range(3))
			1: send_key(cons_keys[$urandom_range(cons_keys.size() - 1)]);
			2: begin
				e = FINAL_MERGE[$urandom_range(10)];
				send_key(key_for(e[23:16]));
				send_key(key_for(e[15:8]));
			end
			3: begin
				send_key(cons_keys[$urandom_range(cons_keys.size() - 1)]);
				send_key(hjc_pkg::KEY_BKSP);
			end
			default: ;
		endcase
		if ($urandom_range(3) == 0) begin
			send_key(vowel_keys[$urandom_range(vowel_keys.size() - 1)]);
		end
	endtask

	task automatic test_directed();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		set_mode(1'b0);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(hjc_pkg::KEY_BKSP);
		send_text("rsk");
		send_text("kh");
		send_text("dhkfrt");
		send_text("k");
		repeat (3) send_key(hjc_pkg::KEY_BKSP);
		send_text("dkfrk");
		send_text("rkQ ");
		send_key(8'h7F);
	endtask

	task automatic test_input_mode();
		src_idle_pct  = 20;
		snk_stall_pct = 20;
		send_text("rk");
		set_mode(1'b1);
		send_key(hjc_pkg::KEY_BKSP);
		send_text("x");
		repeat (20) send_key(pick_key());
		send_text("r");
		set_mode(1'b0);
		send_text("k");
	endtask

	task automatic test_random_composition();
		int target;
		for (int p = 0; p < 4; p++) begin
			src_idle_pct  = SRC_IDLE[p];
			snk_stall_pct = SNK_IDLE[p];
			target        = keys_sent + 20;
			while (keys_sent < target) begin
				if ($urandom_range(9) < 7) begin
					send_syllable();
				end else begin
					send_key(pick_key());
				end
				if ($urandom_range(19) == 0) begin
					wait_all_out();
				end
			end
		end
	endtask

	task automatic test_pressure();
		key_ch.valid  = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		@(posedge clk);
		hold_req = 80;
		@(negedge clk);
		repeat (6) send_syllable();
		wait_all_out();
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				res_ch.ready = ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		johab_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (outputs_due.size() == 0) begin
				$error("unexpected result transaction: kind %0d code %h last %0d",
					res_ch.kind, res_ch.code, res_ch.last);
				fail_cnt++;
			end else begin
				want = outputs_due.pop_front();
				if (res_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
					fail_cnt++;
				end
				if (res_ch.code !== want.code) begin
					$error("code: expected %h, got %h", want.code, res_ch.code);
					fail_cnt++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res_ch.last);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("hangul_two_set_johab_composer_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		key_ch.valid      = 1'b0;
		key_ch.key_code   = 8'h00;
		cfg_ch.valid      = 1'b0;
		cfg_ch.input_mode = 1'b0;
		mode_q            = 1'b0;
		comp_phase        = hjc_pkg::PH_START;
		comp_depth        = 0;
		refeed_n          = 0;
		src_idle_pct      = 0;
		snk_stall_pct     = 0;
		hold_req          = 0;
		keys_sent         = 0;
		fail_cnt          = 0;
		cycle_cnt         = 0;
		fill_key_sets();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_input_mode();
		test_random_composition();
		test_pressure();

		wait_all_out();
		repeat (16) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("hangul_two_set_johab_composer_top_tb OK");
		end else begin
			$display("hangul_two_set_johab_composer_top_tb NOT OK");
		end
		$finish;
	end

endmodule
